// ----- hdl/ual_pkg.sv -----
// Package with the shared types, constants and the lockout delay table of the attempt limiter.
`default_nettype none
package ual_pkg;

   // Policy constants.
   localparam int ATTEMPT_MAX = 10;
   localparam int SECRET_BITS = 64;
   localparam int TABLE_TOP   = 10;

   // Field widths.
   localparam int MODE_W      = 2;
   localparam int SECRET_W    = 64;
   localparam int STATUS_W    = 3;
   localparam int DELAY_W     = 21;
   localparam int COUNT_W     = 32;
   localparam int TABLE_IDX_W = 4;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 64;

   // Queue between the front and back parts; the depth must be a power of two.
   localparam int QUEUE_DEPTH   = 2;
   localparam int QUEUE_PTR_W   = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_COUNT_W = $clog2(QUEUE_DEPTH + 1);

   // Configuration register indexes.
   localparam logic [CSR_INDEX_W-1:0] CSR_WIPE_POLICY        = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SECRET_PROVISIONED = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_REF_SECRET         = 2'd2;

   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   typedef enum logic [MODE_W-1:0] {
      MODE_ATTEMPT = 2'd0,
      MODE_TICK    = 2'd1,
      MODE_CLEAR   = 2'd2,
      MODE_UNUSED  = 2'd3
   } mode_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 3'd0,
      ST_NO_SECRET = 3'd1,
      ST_WAITING   = 3'd2,
      ST_WRONG     = 3'd3,
      ST_LIMIT     = 3'd4
   } status_type;

   // What the back part has to do with one word.
   typedef enum logic [2:0] {
      CMD_NO_SECRET,
      CMD_ATTEMPT,
      CMD_TICK,
      CMD_CLEAR,
      CMD_IGNORE
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic         match;
   } cmd_type;

   // Lockout delay in milliseconds for a clamped retry count.
   function automatic logic [DELAY_W-1:0] lockout_delay(input logic [TABLE_IDX_W-1:0] idx);
      logic [DELAY_W-1:0] delay;
      case (idx)
         4'd4, 4'd5:   delay = DELAY_W'(10 * 1000);
         4'd6:         delay = DELAY_W'(60 * 1000);
         4'd7:         delay = DELAY_W'(60 * 1000 * 5);
         4'd8:         delay = DELAY_W'(60 * 1000 * 10);
         4'd9, 4'd10:  delay = DELAY_W'(60 * 1000 * 30);
         default:      delay = '0;
      endcase
      return delay;
   endfunction

endpackage
`default_nettype wire

// ----- hdl/ual_if.sv -----
// Valid/ready channel interfaces for the request and response words.
`default_nettype none
interface ual_req_if
   import ual_pkg::*;
();
   logic                valid;
   logic                ready;
   logic [MODE_W-1:0]   mode;
   logic [SECRET_W-1:0] attempt_secret;

   modport source (output valid, output mode, output attempt_secret, input ready);
   modport sink   (input valid, input mode, input attempt_secret, output ready);
endinterface

interface ual_rsp_if
   import ual_pkg::*;
();
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [DELAY_W-1:0]  delay_left_ms;
   logic [COUNT_W-1:0]  attempt_count;
   logic                unlock_grant;
   logic                wipe_request;

   modport source (output valid, output status, output delay_left_ms, output attempt_count,
                   output unlock_grant, output wipe_request, input ready);
   modport sink   (input valid, input status, input delay_left_ms, input attempt_count,
                   input unlock_grant, input wipe_request, output ready);
endinterface
`default_nettype wire

// ----- hdl/ual_front.sv -----
// Front part: accepts request words, decodes the mode and compares the offered secret.
`default_nettype none
module ual_front
   import ual_pkg::*;
(
   ual_req_if.sink                  req,
   input  wire logic                secret_provisioned,
   input  wire logic [SECRET_W-1:0] ref_secret,
   input  wire logic                queue_full,
   output logic                     push,
   output cmd_type                  push_cmd
);

   logic secret_match;

   // A word is taken whenever the queue has room.
   assign req.ready = !queue_full;
   assign push      = req.valid && !queue_full;

   // Only the low SECRET_BITS bits of each secret take part in the compare.
   assign secret_match = (req.attempt_secret[SECRET_BITS-1:0] ==
                          ref_secret[SECRET_BITS-1:0]);

   // Classify the word; the configuration must be steady while words are in flight, which the block does not enforce.
   always_comb begin
      push_cmd.match = secret_match;
      case (mode_type'(req.mode))
         MODE_ATTEMPT: begin
            push_cmd.kind = secret_provisioned ? CMD_ATTEMPT : CMD_NO_SECRET;
         end
         MODE_TICK:  push_cmd.kind = CMD_TICK;
         MODE_CLEAR: push_cmd.kind = CMD_CLEAR;
         default:    push_cmd.kind = CMD_IGNORE;
      endcase
   end

endmodule
`default_nettype wire

// ----- hdl/ual_queue.sv -----
// Short command queue that decouples the front part from the back part.
`default_nettype none
module ual_queue
   import ual_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire cmd_type push_cmd,
   output logic         full,
   input  wire logic    pop,
   output logic         head_valid,
   output cmd_type      head_cmd
);

   cmd_type                  entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_COUNT_W-1:0] count_ff, count_in;

   assign full       = (count_ff == QUEUE_COUNT_W'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_cmd   = entry_ff[rd_ptr_ff];

   // Pointers wrap naturally since the depth is a power of two.
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage of the queued commands.
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule
`default_nettype wire

// ----- hdl/ual_back.sv -----
// Back part: applies each command to the retry count and lockout timer and registers the response.
`default_nettype none
module ual_back
   import ual_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    wipe_policy,
   input  wire logic    head_valid,
   input  wire cmd_type head_cmd,
   output logic         pop,
   ual_rsp_if.source    rsp
);

   logic [COUNT_W-1:0]     retry_count_ff, retry_count_in;
   logic [DELAY_W-1:0]     lockout_ff, lockout_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   status_type             status_ff, status_in;
   logic                   grant_ff, grant_in;
   logic                   wipe_ff, wipe_in;
   logic [COUNT_W-1:0]     count_inc;
   logic [TABLE_IDX_W-1:0] table_idx;
   logic                   past_limit;

   // A command is carried out when the output register is free or being emptied.
   assign pop = head_valid && (!rsp_valid_ff || rsp.ready);

   // Saturating increment and the table index clamped to the last entry.
   always_comb begin
      count_inc  = (retry_count_ff == COUNT_MAX) ? retry_count_ff : retry_count_ff + 1'b1;
      past_limit = (count_inc > COUNT_W'(ATTEMPT_MAX));
      if (count_inc >= COUNT_W'(ATTEMPT_MAX)) begin
         table_idx = TABLE_IDX_W'(ATTEMPT_MAX);
      end else begin
         table_idx = count_inc[TABLE_IDX_W-1:0];
      end
      if (table_idx > TABLE_IDX_W'(TABLE_TOP)) begin
         table_idx = TABLE_IDX_W'(TABLE_TOP);
      end
   end

   // State update and response for the head command.
   always_comb begin
      retry_count_in = retry_count_ff;
      lockout_in     = lockout_ff;
      status_in      = ST_OK;
      grant_in       = 1'b0;
      wipe_in        = 1'b0;
      case (head_cmd.kind)
         CMD_NO_SECRET: status_in = ST_NO_SECRET;
         CMD_ATTEMPT: begin
            if (lockout_ff != '0) begin
               status_in = ST_WAITING;
            end else if (head_cmd.match) begin
               retry_count_in = '0;
               lockout_in     = '0;
               grant_in       = 1'b1;
            end else begin
               retry_count_in = count_inc;
               lockout_in     = (count_inc == '0) ? '0 : lockout_delay(table_idx);
               if (past_limit) begin
                  status_in = ST_LIMIT;
                  wipe_in   = wipe_policy;
               end else begin
                  status_in = ST_WRONG;
               end
            end
         end
         CMD_TICK: begin
            if (lockout_ff != '0) begin
               lockout_in = lockout_ff - 1'b1;
            end
         end
         CMD_CLEAR: retry_count_in = '0;
         default: ;
      endcase
      if (pop) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         retry_count_ff <= '0;
         lockout_ff     <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (pop) begin
            retry_count_ff <= retry_count_in;
            lockout_ff     <= lockout_in;
         end
      end
   end

   // Response payload register.
   always_ff @(posedge clock) begin
      if (pop) begin
         status_ff <= status_in;
         grant_ff  <= grant_in;
         wipe_ff   <= wipe_in;
      end
   end

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.status        = status_ff;
   assign rsp.delay_left_ms = lockout_ff;
   assign rsp.attempt_count = retry_count_ff;
   assign rsp.unlock_grant  = grant_ff;
   assign rsp.wipe_request  = wipe_ff;

endmodule
`default_nettype wire

// ----- hdl/unlock_attempt_limiter_unit.sv -----
// Top level of the unlock attempt limiter: configuration registers, front, queue and back.
//
// Usage: each request word carries a mode (attempt, one-millisecond tick, or
// retry-counter clear) and an offered secret. Every request word yields exactly
// one response word with the status, the lockout milliseconds left, the retry
// count, the unlock grant and the wipe request, in request order.
// The csr port writes the wipe policy, the provisioned flag and the reference
// secret; write it only while no words are in flight.
// Each accepted word is stored in the command queue, and its response is then
// registered in the back part. Throughput is one word per cycle while the receiver
// takes responses, as the compare and the count and table update are combinational.
// Reset clears the configuration, the retry count, the lockout timer and the
// two-entry command queue; no response is pending after reset.
// When the receiver stalls, the response stays registered, the queue takes up to
// two more words, and then req_chan.ready drops until the receiver takes a word.
`default_nettype none
module unlock_attempt_limiter_unit
   import ual_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   ual_req_if.sink                     req_chan,
   ual_rsp_if.source                   rsp_chan,
   input  wire logic                   csr_write_enable,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_write_data
);

   logic                wipe_policy_ff;
   logic                secret_provisioned_ff;
   logic [SECRET_W-1:0] ref_secret_ff;
   logic                push;
   cmd_type             push_cmd;
   logic                queue_full;
   logic                pop;
   logic                head_valid;
   cmd_type             head_cmd;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         wipe_policy_ff        <= 1'b0;
         secret_provisioned_ff <= 1'b0;
         ref_secret_ff         <= '0;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_WIPE_POLICY:        wipe_policy_ff        <= csr_write_data[0];
            CSR_SECRET_PROVISIONED: secret_provisioned_ff <= csr_write_data[0];
            CSR_REF_SECRET:         ref_secret_ff         <= csr_write_data[SECRET_W-1:0];
            default: ;
         endcase
      end
   end

   ual_front u_front (
      .req                (req_chan),
      .secret_provisioned (secret_provisioned_ff),
      .ref_secret         (ref_secret_ff),
      .queue_full         (queue_full),
      .push               (push),
      .push_cmd           (push_cmd)
   );

   ual_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_cmd   (push_cmd),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_cmd   (head_cmd)
   );

   ual_back u_back (
      .clock       (clock),
      .reset       (reset),
      .wipe_policy (wipe_policy_ff),
      .head_valid  (head_valid),
      .head_cmd    (head_cmd),
      .pop         (pop),
      .rsp         (rsp_chan)
   );

   // A granted unlock clears the count and the lockout.
   assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.unlock_grant |->
         rsp_chan.status == ST_OK && rsp_chan.attempt_count == '0 &&
         rsp_chan.delay_left_ms == '0)
      else $error("unlock grant with nonzero count or lockout");

   // A wipe request only comes with the limit status and the wipe response configured.
   assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.wipe_request |->
         rsp_chan.status == ST_LIMIT && wipe_policy_ff)
      else $error("wipe request without limit response");

   // The limit status means the count has passed the attempt limit.
   assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.status == ST_LIMIT |->
         rsp_chan.attempt_count > COUNT_W'(ATTEMPT_MAX))
      else $error("limit status below the attempt limit");

   // A refused attempt while waiting reports a running lockout.
   assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.status == ST_WAITING |-> rsp_chan.delay_left_ms != '0)
      else $error("waiting status with no lockout running");

endmodule
`default_nettype wire
